/* hw/rtl/mh64_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh64_pkg
// Shared constants and types for the 64-bit Murmur hash block.
// ----------------------------------------------------------------------------
package mh64_pkg;

   localparam logic [63:0] MUL_CONST = 64'hc6a4a7935bd1e995;
   localparam int          SHIFT_AMT = 47;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_FULL,
      KIND_TAIL
   } kind_type;

   typedef struct packed {
      logic        first;
      logic [31:0] length;
      kind_type    kind;
      logic [63:0] word;
      logic        last;
   } item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEED,
      ST_BODY,
      ST_K1,
      ST_K2,
      ST_HMUL,
      ST_CHECK,
      ST_FMUL,
      ST_EMIT
   } state_type;

endpackage

/* hw/rtl/mh64_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh64_front
// Accepts input words, tracks message start, masks and classifies each word.
// ----------------------------------------------------------------------------
module mh64_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [63:0]          req_data_word,
   input  logic [3:0]           req_byte_count,
   input  logic                 req_last_word,
   input  logic [31:0]          req_message_length,
   input  logic                 queue_full,
   output logic                 push,
   output mh64_pkg::item_type   push_item
);

   logic in_msg_ff;
   logic in_msg_in;

   assign req_stall = queue_full;
   assign push      = req_valid & ~queue_full;

   always_comb begin
      push_item.first  = ~in_msg_ff;
      push_item.length = req_message_length;
      push_item.last   = req_last_word;
      push_item.word   = req_data_word;
      if (req_byte_count >= 4'd8) begin
         push_item.kind = mh64_pkg::KIND_FULL;
      end else if (req_byte_count == 4'd0) begin
         push_item.kind = mh64_pkg::KIND_NONE;
      end else begin
         push_item.kind = mh64_pkg::KIND_TAIL;
         // drop bytes beyond the count
         for (int i = 0; i < 8; i++) begin
            if (4'(i) >= req_byte_count) begin
               push_item.word[i*8 +: 8] = 8'h00;
            end
         end
      end
   end

   always_comb begin
      in_msg_in = in_msg_ff;
      if (push) begin
         in_msg_in = ~req_last_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_msg_ff <= 1'b0;
      end else begin
         in_msg_ff <= in_msg_in;
      end
   end

endmodule

/* hw/rtl/mh64_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh64_queue
// Short queue of classified words between the front and the back.
// ----------------------------------------------------------------------------
module mh64_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mh64_pkg::item_type   push_item,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output mh64_pkg::item_type   head_item
);

   mh64_pkg::item_type               mem_ff [mh64_pkg::QUEUE_DEPTH];
   logic [mh64_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [mh64_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [mh64_pkg::QCNT_W-1:0]      cnt_ff, cnt_in;

   assign full      = (cnt_ff == mh64_pkg::QCNT_W'(mh64_pkg::QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == mh64_pkg::QPTR_W'(mh64_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == mh64_pkg::QPTR_W'(mh64_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

/* hw/rtl/mh64_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh64_mul
// Low 64 bits of a 64x64 product, one 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
module mh64_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic        done,
   output logic [63:0] product
);

   logic [63:0] a_ff, b_ff;
   logic [63:0] acc_ff, acc_in;
   logic [1:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [31:0] x, y;
   logic [63:0] prod;

   assign prod    = x * y;
   assign done    = done_ff;
   assign product = acc_ff;

   always_comb begin
      x       = a_ff[31:0];
      y       = b_ff[31:0];
      acc_in  = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         case (step_ff)
            2'd0: begin
               acc_in = prod;
            end
            2'd1: begin
               x = a_ff[63:32];
               acc_in[63:32] = acc_ff[63:32] + prod[31:0];
            end
            default: begin
               y = b_ff[63:32];
               acc_in[63:32] = acc_ff[63:32] + prod[31:0];
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         endcase
         step_in = step_ff + 2'd1;
      end
      if (start) begin
         busy_in = 1'b1;
         step_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (start) begin
         a_ff <= op_a;
         b_ff <= op_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 2'd0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

/* hw/rtl/mh64_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh64_back
// Sequencer that mixes words into the running hash and finalizes the digest.
// ----------------------------------------------------------------------------
module mh64_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 not_empty,
   input  mh64_pkg::item_type   head_item,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [63:0]          rsp_digest
);

   mh64_pkg::state_type state_ff, state_in;
   mh64_pkg::item_type  item_ff;
   logic [63:0]         hash_ff, hash_in;
   logic [63:0]         fin_ff, fin_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [63:0]         rsp_digest_ff;
   logic                load_out;
   logic                mul_start;
   logic [63:0]         mul_a;
   logic                mul_done;
   logic [63:0]         mul_p;

   mh64_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mh64_pkg::MUL_CONST),
      .done    (mul_done),
      .product (mul_p)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_digest = rsp_digest_ff;

   always_comb begin
      state_in  = state_ff;
      hash_in   = hash_ff;
      fin_in    = fin_ff;
      pop       = 1'b0;
      mul_start = 1'b0;
      mul_a     = hash_ff;
      load_out  = 1'b0;
      unique case (state_ff)
         mh64_pkg::ST_IDLE: begin
            if (not_empty) begin
               pop = 1'b1;
               if (head_item.first) begin
                  mul_start = 1'b1;
                  mul_a     = {32'd0, head_item.length};
                  state_in  = mh64_pkg::ST_SEED;
               end else begin
                  state_in  = mh64_pkg::ST_BODY;
               end
            end
         end
         mh64_pkg::ST_SEED: begin
            if (mul_done) begin
               hash_in  = mul_p;
               state_in = mh64_pkg::ST_BODY;
            end
         end
         mh64_pkg::ST_BODY: begin
            unique case (item_ff.kind)
               mh64_pkg::KIND_FULL: begin
                  mul_start = 1'b1;
                  mul_a     = item_ff.word;
                  state_in  = mh64_pkg::ST_K1;
               end
               mh64_pkg::KIND_TAIL: begin
                  mul_start = 1'b1;
                  mul_a     = hash_ff ^ item_ff.word;
                  state_in  = mh64_pkg::ST_HMUL;
               end
               default: begin
                  state_in  = mh64_pkg::ST_CHECK;
               end
            endcase
         end
         mh64_pkg::ST_K1: begin
            if (mul_done) begin
               mul_start = 1'b1;
               mul_a     = mul_p ^ (mul_p >> mh64_pkg::SHIFT_AMT);
               state_in  = mh64_pkg::ST_K2;
            end
         end
         mh64_pkg::ST_K2: begin
            if (mul_done) begin
               mul_start = 1'b1;
               mul_a     = hash_ff ^ mul_p;
               state_in  = mh64_pkg::ST_HMUL;
            end
         end
         mh64_pkg::ST_HMUL: begin
            if (mul_done) begin
               hash_in  = mul_p;
               state_in = mh64_pkg::ST_CHECK;
            end
         end
         mh64_pkg::ST_CHECK: begin
            if (item_ff.last) begin
               mul_start = 1'b1;
               mul_a     = hash_ff ^ (hash_ff >> mh64_pkg::SHIFT_AMT);
               state_in  = mh64_pkg::ST_FMUL;
            end else begin
               state_in  = mh64_pkg::ST_IDLE;
            end
         end
         mh64_pkg::ST_FMUL: begin
            if (mul_done) begin
               fin_in   = mul_p ^ (mul_p >> mh64_pkg::SHIFT_AMT);
               state_in = mh64_pkg::ST_EMIT;
            end
         end
         mh64_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_out = 1'b1;
               state_in = mh64_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mh64_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff <= hash_in;
      fin_ff  <= fin_in;
      if (pop) begin
         item_ff <= head_item;
      end
      if (load_out) begin
         rsp_digest_ff <= fin_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mh64_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hw/rtl/murmur_64bit_hash_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur_64bit_hash_top
// MurmurHash64A (seed zero) over little-endian 64-bit message words.
// ----------------------------------------------------------------------------
//  channel  | direction | ports                                   | per word
//  req      | in        | valid, stall, data_word, byte_count,    | one word
//           |           | last_word, message_length               |
//  rsp      | out       | valid, stall, digest                    | one digest
//
//  One shared multiplier forms each 64x64 product in three 32x32 steps. A full
//  word takes three products, a tail word one, an empty word none; the first
//  word of a message adds one for the length seed, the last adds one for the
//  finalizer. A two-word queue decouples req from the sequencer.
//  Synchronous reset clears control state; rsp_stall holds the digest in the
//  output register while later words keep entering the queue until it fills.
// ----------------------------------------------------------------------------
module murmur_64bit_hash_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_data_word,
   input  logic [3:0]  req_byte_count,
   input  logic        req_last_word,
   input  logic [31:0] req_message_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest
);

   logic                queue_full;
   logic                push;
   mh64_pkg::item_type  push_item;
   logic                pop;
   logic                not_empty;
   mh64_pkg::item_type  head_item;

   mh64_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_word      (req_data_word),
      .req_byte_count     (req_byte_count),
      .req_last_word      (req_last_word),
      .req_message_length (req_message_length),
      .queue_full         (queue_full),
      .push               (push),
      .push_item          (push_item)
   );

   mh64_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (not_empty),
      .head_item (head_item)
   );

   mh64_back u_back (
      .clock      (clock),
      .reset      (reset),
      .not_empty  (not_empty),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_digest (rsp_digest)
   );

endmodule

/* tb/murmur_64bit_hash_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur_64bit_hash_top_test
// Feeds a short table of edge-case messages, then random well-formed and
// malformed word streams under four sender/receiver idling mixes. Each digest
// is checked in order against its typed row or an in-bench MurmurHash64A model.
// ----------------------------------------------------------------------------
module murmur_64bit_hash_top_test;

   localparam logic [63:0] HASH_MUL     = 64'hc6a4a7935bd1e995;
   localparam int          HASH_SHIFT   = 47;
   localparam int          PHASE_WORDS  = 400;
   localparam int          NUM_PHASES   = 4;
   localparam int          DIRECTED_NUM = 19;

   typedef struct packed {
      logic [63:0] data;
      logic [3:0]  nbytes;
      logic        final_word;
      logic [31:0] msg_len;
      logic        typed;
      logic [63:0] digest;
   } word_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_data_word = 64'd0;
   logic [3:0]  req_byte_count = 4'd0;
   logic        req_last_word = 1'b0;
   logic [31:0] req_message_length = 32'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_digest;

   logic [63:0] hash_acc = 64'd0;
   logic        msg_open = 1'b0;
   logic [63:0] digests_pending [$];

   int send_gap_pct   = 0;
   int recv_stall_pct = 0;
   int words_sent     = 0;
   int messages_sent  = 0;
   int digests_seen   = 0;
   int errors         = 0;

   word_row_type directed_rows [0:DIRECTED_NUM-1] = '{
      '{64'h0,                 4'd0,  1'b1, 32'd0,          1'b1, 64'h0},
      '{64'hffffffffffffffff,  4'd0,  1'b1, 32'hffffffff,   1'b0, 64'h0},
      '{64'h0,                 4'd8,  1'b1, 32'd8,          1'b0, 64'h0},
      '{64'hffffffffffffffff,  4'd8,  1'b1, 32'd8,          1'b0, 64'h0},
      '{64'hffffffffffffffff,  4'd1,  1'b1, 32'd1,          1'b0, 64'h0},
      '{64'hffffffffffffffff,  4'd2,  1'b1, 32'd2,          1'b0, 64'h0},
      '{64'hffffffffffffffff,  4'd3,  1'b1, 32'd3,          1'b0, 64'h0},
      '{64'hffffffffffffffff,  4'd4,  1'b1, 32'd4,          1'b0, 64'h0},
      '{64'hffffffffffffffff,  4'd5,  1'b1, 32'd5,          1'b0, 64'h0},
      '{64'hffffffffffffffff,  4'd6,  1'b1, 32'd6,          1'b0, 64'h0},
      '{64'hffffffffffffffff,  4'd7,  1'b1, 32'd7,          1'b0, 64'h0},
      '{64'h0123456789abcdef,  4'd9,  1'b1, 32'd8,          1'b0, 64'h0},
      '{64'h0123456789abcdef,  4'd15, 1'b1, 32'd8,          1'b0, 64'h0},
      '{64'hfedcba9876543210,  4'd8,  1'b0, 32'd20,         1'b0, 64'h0},
      '{64'h5555aaaa5555aaaa,  4'd0,  1'b0, 32'd0,          1'b0, 64'h0},
      '{64'haaaa5555aaaa5555,  4'd3,  1'b0, 32'd0,          1'b0, 64'h0},
      '{64'h8000000000000001,  4'd8,  1'b1, 32'd0,          1'b0, 64'h0},
      '{64'hffffffffffffffff,  4'd8,  1'b1, 32'hffffffff,   1'b0, 64'h0},
      '{64'h7fffffffffffffff,  4'd12, 1'b1, 32'd0,          1'b0, 64'h0}
   };

   murmur_64bit_hash_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_word      (req_data_word),
      .req_byte_count     (req_byte_count),
      .req_last_word      (req_last_word),
      .req_message_length (req_message_length),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digest         (rsp_digest)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("timeout with %0d digests pending", digests_pending.size());
      $display("simulation failed");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   function automatic logic [63:0] mix_word(input logic [63:0] k);
      k = k * HASH_MUL;
      k = k ^ (k >> HASH_SHIFT);
      k = k * HASH_MUL;
      return k;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic absorb_word(input logic [63:0] data, input logic [3:0] nbytes,
                              input logic final_word, input logic [31:0] msg_len,
                              output logic produced, output logic [63:0] digest);
      logic [63:0] mask;
      logic [63:0] h;
      if (!msg_open) begin
         hash_acc = {32'd0, msg_len} * HASH_MUL;
         msg_open = 1'b1;
      end
      if (nbytes >= 4'd8) begin
         hash_acc = (hash_acc ^ mix_word(data)) * HASH_MUL;
      end else if (nbytes[2:0] != 3'd0) begin
         mask = (64'd1 << {nbytes[2:0], 3'b000}) - 64'd1;
         hash_acc = (hash_acc ^ (data & mask)) * HASH_MUL;
      end
      produced = final_word;
      digest = 64'd0;
      if (final_word) begin
         h = hash_acc;
         h = h ^ (h >> HASH_SHIFT);
         h = h * HASH_MUL;
         h = h ^ (h >> HASH_SHIFT);
         digest = h;
         msg_open = 1'b0;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         digests_seen++;
         if (digests_pending.size() == 0) begin
            report_mismatch("digest with none pending", rsp_digest, 64'd0);
         end else begin
            if (rsp_digest !== digests_pending[0]) begin
               report_mismatch("digest", rsp_digest, digests_pending[0]);
            end
            void'(digests_pending.pop_front());
         end
      end
   end

   task automatic send_word(input logic [63:0] data, input logic [3:0] nbytes,
                            input logic final_word, input logic [31:0] msg_len,
                            input logic typed, input logic [63:0] typed_digest);
      logic        produced;
      logic [63:0] predicted;
      // idle the sender
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_data_word      <= data;
      req_byte_count     <= nbytes;
      req_last_word      <= final_word;
      req_message_length <= msg_len;
      do @(posedge clock); while (req_stall);
      words_sent++;
      if (final_word) messages_sent++;
      absorb_word(data, nbytes, final_word, msg_len, produced, predicted);
      if (produced) digests_pending.push_back(typed ? typed_digest : predicted);
   endtask

   task automatic send_message();
      int unsigned pick;
      int unsigned total;
      int unsigned nfull;
      int unsigned rem;
      int unsigned nwords;
      pick = $urandom_range(99);
      if (pick < 80) begin
         pick = $urandom_range(99);
         if (pick < 70) total = $urandom_range(24);
         else if (pick < 95) total = $urandom_range(100, 25);
         else total = $urandom_range(300, 101);
         nfull = total / 8;
         rem   = total % 8;
         if (total == 0) send_word(rand64(), 4'd0, 1'b1, 32'd0, 1'b0, 64'd0);
         for (int i = 0; i < nfull; i++) begin
            send_word(rand64(), 4'd8, (rem == 0) && (i == nfull - 1), total, 1'b0, 64'd0);
         end
         if (rem != 0) send_word(rand64(), rem[3:0], 1'b1, total, 1'b0, 64'd0);
      end else begin
         // malformed: odd counts anywhere, length unrelated to the words
         nwords = $urandom_range(6, 1);
         for (int i = 0; i < nwords; i++) begin
            send_word(rand64(), 4'($urandom_range(15)), i == nwords - 1, $urandom,
                      1'b0, 64'd0);
         end
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (digests_pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      int phase_end;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < DIRECTED_NUM; i++) begin
         send_word(directed_rows[i].data, directed_rows[i].nbytes,
                   directed_rows[i].final_word, directed_rows[i].msg_len,
                   directed_rows[i].typed, directed_rows[i].digest);
      end
      drain();
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_gap_pct = 45; recv_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  recv_stall_pct = 45; end
            default: begin send_gap_pct = 36; recv_stall_pct = 36; end
         endcase
         phase_end = words_sent + PHASE_WORDS;
         while (words_sent < phase_end) send_message();
         // hold off until every digest is back
         drain();
      end
      repeat (60) @(posedge clock);
      $display("covered %0d words in %0d messages, %0d digests compared", words_sent,
               messages_sent, digests_seen);
      $display("phases: no idling, sender gaps, receiver stalls, both; %0d mismatches",
               errors);
      if (errors == 0 && digests_pending.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
